FILE: rtl/core/hfsc_pkg.sv
// Package for the heatsink fan speed curve block.
// Holds register indexes, curve constants and the range-check helper.
// Depends on nothing; imported by heatsink_fan_speed_curve_core and its testbench.
package hfsc_pkg;

    localparam int TEMP_W = 16;   // width of temperature and override fields
    localparam int CFG_W  = 16;   // width of the configuration data bus
    localparam int IDX_W  = 3;    // width of the configuration register index
    localparam int DUTY_W = 7;    // width of the duty result and curve operands
    localparam int NUM_W  = 14;   // width of (t - lo) * (100 - s)
    localparam int REM_W  = 15;   // width of the rounded dividend 2*num + den

    localparam logic [IDX_W-1:0] REG_TEMP_MIN      = 3'd0;
    localparam logic [IDX_W-1:0] REG_TEMP_MAX      = 3'd1;
    localparam logic [IDX_W-1:0] REG_START_LOAD    = 3'd2;
    localparam logic [IDX_W-1:0] REG_CTRL_MODE     = 3'd3;
    localparam logic [IDX_W-1:0] REG_OVERRIDE_TEMP = 3'd4;

    localparam logic [7:0] MODE_OVERRIDE_A = 8'h1A;
    localparam logic [7:0] MODE_OVERRIDE_B = 8'h2A;

    localparam logic [DUTY_W-1:0] TEMP_MIN_LIMIT   = 7'd70;
    localparam logic [DUTY_W-1:0] TEMP_MIN_DEFAULT = 7'd40;
    localparam logic [DUTY_W-1:0] TEMP_MAX_LIMIT   = 7'd90;
    localparam logic [DUTY_W-1:0] TEMP_MAX_DEFAULT = 7'd55;
    localparam logic [DUTY_W-1:0] START_LIMIT      = 7'd60;
    localparam logic [DUTY_W-1:0] START_DEFAULT    = 7'd40;
    localparam logic [DUTY_W-1:0] DUTY_FULL        = 7'd100;
    localparam logic [DUTY_W-1:0] DUTY_OFF         = 7'd0;

    // A signed 16-bit register value inside 0..upper is used as is,
    // anything else is replaced by the default.
    function automatic logic [DUTY_W-1:0] limit_or_default(
        input logic [CFG_W-1:0]  value,
        input logic [DUTY_W-1:0] upper,
        input logic [DUTY_W-1:0] dflt
    );
        logic in_range;
        in_range = !value[CFG_W-1] && (value <= CFG_W'(upper));
        return in_range ? value[DUTY_W-1:0] : dflt;
    endfunction

endpackage

FILE: rtl/core/heatsink_fan_speed_curve_core.sv
// Heatsink fan speed curve: running maximum of module temperatures and
// a linear fan duty curve with a minimum running duty.
// Depends on hfsc_pkg.
//
// Usage: a temperature is transferred at a rising edge where start is high
// and busy is low. Items without last only update the running maximum,
// and busy stays low. An item with last ends a control pass:
// the block goes busy, evaluates the curve and presents one result on
// fan_duty and hottest with done high for exactly one cycle. A flat curve
// (off or full speed) is settled in the calc state; an interpolated duty
// also passes through the divide state, where a single compare-and-subtract
// unit produces one quotient bit per cycle after the multiply in the calc
// state. The receiver cannot stall; each result is
// taken in its done cycle, and a new item may be transferred in that
// same cycle. Configuration writes use cfg_valid/cfg_ready, always ready;
// indexes beyond the register list are ignored, and writes are expected
// only while the block is idle. Reset restores all registers to their
// defaults and clears the running maximum.
module heatsink_fan_speed_curve_core #(
    parameter int TEMP_WIDTH = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [hfsc_pkg::TEMP_W-1:0]    temperature,
    input  logic                           last,
    output logic                           done,
    output logic [hfsc_pkg::DUTY_W-1:0]    fan_duty,
    output logic [hfsc_pkg::TEMP_W-1:0]    hottest,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [hfsc_pkg::IDX_W-1:0]     cfg_index,
    input  logic [hfsc_pkg::CFG_W-1:0]     cfg_data
);
    import hfsc_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CALC,
        ST_DIV
    } state_t;

    // Configuration registers.
    logic [CFG_W-1:0]  temp_min_reg;
    logic [CFG_W-1:0]  temp_max_reg;
    logic [CFG_W-1:0]  start_load_reg;
    logic [7:0]        ctrl_mode_reg;
    logic [TEMP_W-1:0] override_temp_reg;

    // Sequencer and datapath registers.
    state_t                state_reg, state_next;
    logic [TEMP_WIDTH-1:0] max_reg, max_next;
    logic [TEMP_W-1:0]     hot_reg, hot_next;
    logic [REM_W-1:0]      rem_reg, rem_next;
    logic [REM_W-1:0]      dvs_reg, dvs_next;
    logic [DUTY_W-1:0]     quo_reg, quo_next;
    logic [2:0]            cnt_reg, cnt_next;
    logic                  done_reg, done_next;
    logic [DUTY_W-1:0]     duty_reg, duty_next;

    logic                  accept;
    logic [TEMP_WIDTH-1:0] temp_in;
    logic [TEMP_WIDTH-1:0] new_max;
    logic                  override_on;
    logic [DUTY_W-1:0]     lo, hi, s_load;
    logic [DUTY_W-1:0]     t_off, slope_span, den;
    logic [NUM_W-1:0]      num;
    logic                  sub_ok;
    logic [DUTY_W-1:0]     quo_step;

    assign cfg_ready = 1'b1;
    assign busy      = (state_reg != ST_IDLE);
    assign accept    = start && !busy;
    assign done      = done_reg;
    assign fan_duty  = duty_reg;
    assign hottest   = hot_reg;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            temp_min_reg      <= CFG_W'(TEMP_MIN_DEFAULT);
            temp_max_reg      <= CFG_W'(TEMP_MAX_DEFAULT);
            start_load_reg    <= CFG_W'(START_DEFAULT);
            ctrl_mode_reg     <= '0;
            override_temp_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_TEMP_MIN:      temp_min_reg      <= cfg_data;
                REG_TEMP_MAX:      temp_max_reg      <= cfg_data;
                REG_START_LOAD:    start_load_reg    <= cfg_data;
                REG_CTRL_MODE:     ctrl_mode_reg     <= cfg_data[7:0];
                REG_OVERRIDE_TEMP: override_temp_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Range-substituted thresholds; only the user keeps them put while busy.
    assign lo     = limit_or_default(temp_min_reg, TEMP_MIN_LIMIT, TEMP_MIN_DEFAULT);
    assign hi     = limit_or_default(temp_max_reg, TEMP_MAX_LIMIT, TEMP_MAX_DEFAULT);
    assign s_load = limit_or_default(start_load_reg, START_LIMIT, START_DEFAULT);

    assign temp_in     = temperature[TEMP_WIDTH-1:0];
    assign new_max     = (temp_in > max_reg) ? temp_in : max_reg;
    assign override_on = (ctrl_mode_reg == MODE_OVERRIDE_A) ||
                         (ctrl_mode_reg == MODE_OVERRIDE_B);

    // Interpolation operands, used only when lo < hot < hi, so hot fits in
    // the narrow width and both differences are positive.
    assign t_off      = hot_reg[DUTY_W-1:0] - lo;
    assign slope_span = DUTY_FULL - s_load;
    assign den        = hi - lo;
    assign num        = NUM_W'(t_off) * NUM_W'(slope_span);

    // Restoring-division step: one quotient bit per cycle.
    assign sub_ok   = (rem_reg >= dvs_reg);
    assign quo_step = {quo_reg[DUTY_W-2:0], sub_ok};

    always_comb begin
        state_next = state_reg;
        max_next   = max_reg;
        hot_next   = hot_reg;
        rem_next   = rem_reg;
        dvs_next   = dvs_reg;
        quo_next   = quo_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        duty_next  = duty_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (last) begin
                        // The last item still takes part in the maximum.
                        hot_next   = override_on ? override_temp_reg : TEMP_W'(new_max);
                        max_next   = '0;
                        state_next = ST_CALC;
                    end else begin
                        max_next = new_max;
                    end
                end
            end
            ST_CALC: begin
                if (hot_reg < TEMP_W'(lo)) begin
                    duty_next  = DUTY_OFF;
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end else if (hot_reg >= TEMP_W'(hi)) begin
                    duty_next  = DUTY_FULL;
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end else if (hot_reg == TEMP_W'(lo)) begin
                    // The fan stays off exactly at the minimum temperature.
                    duty_next  = DUTY_OFF;
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end else begin
                    // Round half up: (2*num + den) / (2*den).
                    rem_next   = {num, 1'b0} + REM_W'(den);
                    dvs_next   = REM_W'(den) << DUTY_W;
                    quo_next   = '0;
                    cnt_next   = 3'(DUTY_W - 1);
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if (sub_ok) begin
                    rem_next = rem_reg - dvs_reg;
                end
                dvs_next = dvs_reg >> 1;
                quo_next = quo_step;
                cnt_next = cnt_reg - 3'd1;
                if (cnt_reg == 3'd0) begin
                    duty_next  = s_load + quo_step;
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg <= ST_IDLE;
            max_reg   <= '0;
            hot_reg   <= '0;
            rem_reg   <= '0;
            dvs_reg   <= '0;
            quo_reg   <= '0;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
            duty_reg  <= '0;
        end else begin
            state_reg <= state_next;
            max_reg   <= max_next;
            hot_reg   <= hot_next;
            rem_reg   <= rem_next;
            dvs_reg   <= dvs_next;
            quo_reg   <= quo_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
            duty_reg  <= duty_next;
        end
    end

`ifndef SYNTHESIS
    // A result only follows a busy cycle, and the block is idle when it shows.
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ($past(busy) && !busy))
        else $error("done without a preceding busy cycle");

    a_duty_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (fan_duty <= DUTY_FULL))
        else $error("fan duty above full speed");

    a_last_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && last) |=> (busy && max_reg == '0))
        else $error("last item did not start the curve or clear the maximum");

    a_plain_item_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && !last) |=> (!busy && !done))
        else $error("item without last caused work or a result");

    a_div_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (rem_reg < (dvs_reg << 1)))
        else $error("division remainder out of range");
`endif

endmodule

FILE: bench/tb_heatsink_fan_speed_curve_core.sv
// Self-checking testbench for heatsink_fan_speed_curve_core: a directed table of
// threshold edge cases, then random control passes under random settings and gaps.
// Depends on hfsc_pkg and the core; results are checked against an in-bench predictor.
module tb_heatsink_fan_speed_curve_core;

    import hfsc_pkg::*;

    localparam int TEMP_WIDTH = 16;
    localparam logic [TEMP_W-1:0] TEMP_MASK = TEMP_W'((32'd1 << TEMP_WIDTH) - 1);

    // Covers the longest evaluation, the divide path, with margin before a
    // register is rewritten or the run is closed.
    localparam int SETTLE_CYCLES   = 12;
    localparam int RESULT_WAIT     = 100;
    localparam int CYCLE_LIMIT     = 200000;
    localparam int MAX_REPORTS     = 50;
    localparam int PHASES          = 8;
    localparam int ITEMS_PER_PHASE = 128;

    // Indexes past the end of the register map; writes there must be dropped.
    localparam logic [IDX_W-1:0] REG_UNMAPPED_LO = 3'd5;
    localparam logic [IDX_W-1:0] REG_UNMAPPED_HI = 3'd7;

    // Mode codes that are not override: plain, one off an override code, all ones.
    localparam logic [7:0] MODE_NORMAL        = 8'h00;
    localparam logic [7:0] MODE_NEAR_OVERRIDE = 8'h1B;
    localparam logic [7:0] MODE_ALL_ONES      = 8'hFF;

    typedef struct packed {
        logic [DUTY_W-1:0] duty;
        logic [TEMP_W-1:0] hot;
    } fan_result_t;

    // One row of the directed table: either a register write or one temperature.
    // Rows with a typed expectation bypass the predictor for the result itself.
    typedef struct packed {
        bit                is_write;
        logic [IDX_W-1:0]  index;
        logic [CFG_W-1:0]  value;
        logic [TEMP_W-1:0] temp;
        logic              is_last;
        bit                typed;
        logic [DUTY_W-1:0] duty;
        logic [TEMP_W-1:0] hot;
    } stim_row_t;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                start;
    logic                busy;
    logic [TEMP_W-1:0]   temperature;
    logic                last;
    logic                done;
    logic [DUTY_W-1:0]   fan_duty;
    logic [TEMP_W-1:0]   hottest;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [IDX_W-1:0]    cfg_index;
    logic [CFG_W-1:0]    cfg_data;

    // Bench copy of the register file and of the running maximum.
    logic [CFG_W-1:0]    model_temp_min;
    logic [CFG_W-1:0]    model_temp_max;
    logic [CFG_W-1:0]    model_start_load;
    logic [7:0]          model_ctrl_mode;
    logic [TEMP_W-1:0]   model_override;
    logic [TEMP_W-1:0]   model_peak;

    fan_result_t         pending_results[$];
    stim_row_t           stim_table[$];
    int                  mismatches = 0;
    int                  cycle_count = 0;

    heatsink_fan_speed_curve_core #(
        .TEMP_WIDTH (TEMP_WIDTH)
    ) u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .temperature (temperature),
        .last        (last),
        .done        (done),
        .fan_duty    (fan_duty),
        .hottest     (hottest),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always #5 clk = ~clk;

    // A hard ceiling on the run. It is far above the slowest legal run, in which
    // every item waits out the longest gap and every pass takes the divide path.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("[%0t] mismatch: %s", $time, msg);
    endtask

    // A threshold register reads as signed; anything outside 0..upper is
    // replaced by the fallback value.
    function automatic int threshold_value(input logic [CFG_W-1:0] value, input int upper,
                                           input int fallback);
        int v;
        v = int'($signed(value));
        if (v < 0 || v > upper)
            return fallback;
        return v;
    endfunction

    // Random threshold: mostly inside the legal range, with a share of values just
    // above it, negative values, arbitrary patterns and the two range ends.
    function automatic logic [CFG_W-1:0] random_threshold(input int upper);
        case ($urandom_range(0, 9))
            0: return CFG_W'(upper + $urandom_range(1, 200));
            1: return CFG_W'($urandom_range(32'h8000, 32'hFFFF));
            2: return CFG_W'($urandom);
            3: return ($urandom_range(0, 1) != 0) ? CFG_W'(0) : CFG_W'(upper);
            default: return CFG_W'($urandom_range(0, upper));
        endcase
    endfunction

    function automatic stim_row_t item_row(input logic [TEMP_W-1:0] t, input logic l);
        stim_row_t r;
        r = '0;
        r.temp = t;
        r.is_last = l;
        return r;
    endfunction

    function automatic stim_row_t checked_row(input logic [TEMP_W-1:0] t,
                                              input logic [DUTY_W-1:0] duty,
                                              input logic [TEMP_W-1:0] hot);
        stim_row_t r;
        r = item_row(t, 1'b1);
        r.typed = 1'b1;
        r.duty = duty;
        r.hot = hot;
        return r;
    endfunction

    function automatic stim_row_t write_row(input logic [IDX_W-1:0] idx,
                                            input logic [CFG_W-1:0] value);
        stim_row_t r;
        r = '0;
        r.is_write = 1'b1;
        r.index = idx;
        r.value = value;
        return r;
    endfunction

    // Writes one register, then drops the channel before returning so that
    // back-to-back writes never raise and lower valid in the same step.
    task automatic write_register(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (cfg_ready !== 1'b1);
        case (idx)
            REG_TEMP_MIN:      model_temp_min   = value;
            REG_TEMP_MAX:      model_temp_max   = value;
            REG_START_LOAD:    model_start_load = value;
            REG_CTRL_MODE:     model_ctrl_mode  = value[7:0];
            REG_OVERRIDE_TEMP: model_override   = value;
            default:           ;
        endcase
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Presents one temperature and holds it until the core takes it. start is
    // left high so that the caller decides whether the next item follows at once.
    // On the transfer the predictor folds the temperature into the running
    // maximum and, on the last item of a pass, queues the expected duty.
    task automatic send_temperature(input logic [TEMP_W-1:0] t, input logic l, input bit typed,
                                    input logic [DUTY_W-1:0] typed_duty,
                                    input logic [TEMP_W-1:0] typed_hot);
        fan_result_t want;
        logic [TEMP_W-1:0] used;
        int lo, hi, s, tt, num, den;
        start       <= 1'b1;
        temperature <= t;
        last        <= l;
        do
            @(posedge clk);
        while (busy !== 1'b0);

        if ((t & TEMP_MASK) > model_peak)
            model_peak = t & TEMP_MASK;
        if (l)
        begin
            used = model_peak;
            if (model_ctrl_mode == MODE_OVERRIDE_A || model_ctrl_mode == MODE_OVERRIDE_B)
                used = model_override;
            lo = threshold_value(model_temp_min, int'(TEMP_MIN_LIMIT), int'(TEMP_MIN_DEFAULT));
            hi = threshold_value(model_temp_max, int'(TEMP_MAX_LIMIT), int'(TEMP_MAX_DEFAULT));
            s  = threshold_value(model_start_load, int'(START_LIMIT), int'(START_DEFAULT));
            tt = int'(used);
            want.hot = used;
            // Below the minimum the fan is off; at or above the maximum it runs flat
            // out, and that check precedes the one exactly at the minimum (off), so
            // an inverted pair of thresholds never reaches the division.
            if (tt < lo)
                want.duty = DUTY_OFF;
            else if (tt >= hi)
                want.duty = DUTY_FULL;
            else if (tt == lo)
                want.duty = DUTY_OFF;
            else
            begin
                // Round half up of (t - lo) * (100 - s) / (hi - lo), exactly.
                num = (tt - lo) * (int'(DUTY_FULL) - s);
                den = hi - lo;
                want.duty = DUTY_W'(s + (2 * num + den) / (2 * den));
            end
            if (typed)
            begin
                want.duty = typed_duty;
                want.hot  = typed_hot;
            end
            pending_results.push_back(want);
            model_peak = '0;
        end
    endtask

    // Waits for every queued result, reports any that never show up, then lets
    // the core settle so that a register write cannot land on work in flight.
    task automatic drain_results();
        int waited;
        waited = 0;
        while (pending_results.size() != 0 && waited < RESULT_WAIT)
        begin
            @(negedge clk);
            waited++;
        end
        if (pending_results.size() != 0)
        begin
            report_mismatch($sformatf("%0d expected results never arrived",
                                      pending_results.size()));
            pending_results.delete();
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Result checker. A result is on the ports for exactly one cycle and is
    // taken at the edge that closes it; it is matched against the oldest
    // expectation, one field at a time.
    always @(posedge clk)
    begin : result_check
        fan_result_t want;
        if (rst_n === 1'b1 && done === 1'b1)
        begin
            if (pending_results.size() == 0)
                report_mismatch($sformatf("unexpected result fan_duty=%0d hottest=%0d",
                                          fan_duty, hottest));
            else
            begin
                want = pending_results.pop_front();
                if (fan_duty !== want.duty)
                    report_mismatch($sformatf("fan_duty %0d, expected %0d (hottest %0d)",
                                              fan_duty, want.duty, want.hot));
                if (hottest !== want.hot)
                    report_mismatch($sformatf("hottest %0d, expected %0d",
                                              hottest, want.hot));
            end
        end
    end

    initial
    begin
        int n;
        int gap;
        int burst_left;
        int pass_left;
        logic [TEMP_W-1:0] t;
        logic [7:0] mode;

        start       <= 1'b0;
        temperature <= '0;
        last        <= 1'b0;
        cfg_valid   <= 1'b0;
        cfg_index   <= '0;
        cfg_data    <= '0;
        rst_n       <= 1'b0;

        model_temp_min   = CFG_W'(TEMP_MIN_DEFAULT);
        model_temp_max   = CFG_W'(TEMP_MAX_DEFAULT);
        model_start_load = CFG_W'(START_DEFAULT);
        model_ctrl_mode  = MODE_NORMAL;
        model_override   = '0;
        model_peak       = '0;

        // Directed table. Under the reset thresholds (40, 55, start 40):
        // zero and all-ones temperatures, exactly at the minimum, exactly at
        // the maximum, and a pass whose hottest module is not the last one.
        stim_table.push_back(checked_row(16'd0, DUTY_OFF, 16'd0));
        stim_table.push_back(item_row(16'hFFFF, 1'b0));
        stim_table.push_back(checked_row(16'd10, DUTY_FULL, 16'hFFFF));
        stim_table.push_back(checked_row(16'd40, DUTY_OFF, 16'd40));
        stim_table.push_back(checked_row(16'd55, DUTY_FULL, 16'd55));
        stim_table.push_back(checked_row(16'd39, DUTY_OFF, 16'd39));
        stim_table.push_back(item_row(16'd30, 1'b0));
        stim_table.push_back(item_row(16'd47, 1'b0));
        stim_table.push_back(item_row(16'd20, 1'b1));
        // A narrow curve from zero where the quotient lands exactly on a half.
        stim_table.push_back(write_row(REG_TEMP_MIN, 16'd0));
        stim_table.push_back(write_row(REG_TEMP_MAX, 16'd8));
        stim_table.push_back(write_row(REG_START_LOAD, 16'd0));
        stim_table.push_back(item_row(16'd1, 1'b1));
        stim_table.push_back(item_row(16'd7, 1'b1));
        // Negative and oversized thresholds fall back to their defaults.
        stim_table.push_back(write_row(REG_TEMP_MIN, 16'hFFFF));
        stim_table.push_back(write_row(REG_TEMP_MAX, 16'h8000));
        stim_table.push_back(write_row(REG_START_LOAD, 16'h7FFF));
        stim_table.push_back(item_row(16'd41, 1'b1));
        // Every threshold at the top of its legal range.
        stim_table.push_back(write_row(REG_TEMP_MIN, 16'd70));
        stim_table.push_back(write_row(REG_TEMP_MAX, 16'd90));
        stim_table.push_back(write_row(REG_START_LOAD, 16'd60));
        stim_table.push_back(item_row(16'd80, 1'b1));
        stim_table.push_back(item_row(16'd89, 1'b1));
        // One past the top falls back to the defaults again.
        stim_table.push_back(write_row(REG_TEMP_MIN, 16'd71));
        stim_table.push_back(write_row(REG_TEMP_MAX, 16'd91));
        stim_table.push_back(write_row(REG_START_LOAD, 16'd61));
        stim_table.push_back(item_row(16'd50, 1'b1));
        // Minimum above maximum: off below the minimum, full speed from it on.
        stim_table.push_back(write_row(REG_TEMP_MIN, 16'd70));
        stim_table.push_back(write_row(REG_TEMP_MAX, 16'd10));
        stim_table.push_back(checked_row(16'd69, DUTY_OFF, 16'd69));
        stim_table.push_back(checked_row(16'd70, DUTY_FULL, 16'd70));
        // Override with both codes; the measured maximum is dropped but cleared.
        stim_table.push_back(write_row(REG_CTRL_MODE, 16'(MODE_OVERRIDE_A)));
        stim_table.push_back(write_row(REG_OVERRIDE_TEMP, 16'hFFFF));
        stim_table.push_back(item_row(16'd5, 1'b0));
        stim_table.push_back(checked_row(16'd3, DUTY_FULL, 16'hFFFF));
        stim_table.push_back(write_row(REG_CTRL_MODE, 16'(MODE_OVERRIDE_B)));
        stim_table.push_back(write_row(REG_OVERRIDE_TEMP, 16'd0));
        stim_table.push_back(checked_row(16'h8000, DUTY_OFF, 16'd0));
        // Near-miss mode codes select no override; writes to unmapped indexes change nothing.
        stim_table.push_back(write_row(REG_CTRL_MODE, {8'hFF, MODE_NEAR_OVERRIDE}));
        stim_table.push_back(write_row(REG_UNMAPPED_LO, 16'hFFFF));
        stim_table.push_back(write_row(REG_UNMAPPED_HI, 16'hFFFF));
        stim_table.push_back(checked_row(16'd100, DUTY_FULL, 16'd100));
        stim_table.push_back(write_row(REG_CTRL_MODE, 16'(MODE_ALL_ONES)));
        stim_table.push_back(item_row(16'h5555, 1'b0));
        stim_table.push_back(checked_row(16'hAAAA, DUTY_FULL, 16'hAAAA));

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed items go back to back; each register write waits for idle.
        foreach (stim_table[i])
        begin
            if (stim_table[i].is_write)
            begin
                start <= 1'b0;
                drain_results();
                write_register(stim_table[i].index, stim_table[i].value);
            end
            else
                send_temperature(stim_table[i].temp, stim_table[i].is_last,
                                 stim_table[i].typed, stim_table[i].duty, stim_table[i].hot);
        end

        // Random part: each phase reprograms a random subset of the registers
        // and then runs control passes of one to eight modules. Temperatures
        // sit mostly between 0 and 100. The sender works in bursts; the gaps
        // between them range over every cycle of the core's evaluation and
        // sometimes well past it.
        for (int phase = 0; phase < PHASES; phase++)
        begin
            start <= 1'b0;
            drain_results();
            if ($urandom_range(0, 3) != 0)
                write_register(REG_TEMP_MIN, random_threshold(int'(TEMP_MIN_LIMIT)));
            if ($urandom_range(0, 3) != 0)
                write_register(REG_TEMP_MAX, random_threshold(int'(TEMP_MAX_LIMIT)));
            if ($urandom_range(0, 3) != 0)
                write_register(REG_START_LOAD, random_threshold(int'(START_LIMIT)));
            if ($urandom_range(0, 1) != 0)
            begin
                case ($urandom_range(0, 3))
                    0: mode = MODE_OVERRIDE_A;
                    1: mode = MODE_OVERRIDE_B;
                    2: mode = MODE_NORMAL;
                    default: mode = 8'($urandom);
                endcase
                write_register(REG_CTRL_MODE, {8'($urandom), mode});
            end
            if ($urandom_range(0, 1) != 0)
                write_register(REG_OVERRIDE_TEMP, ($urandom_range(0, 3) == 0) ?
                               TEMP_W'($urandom) : TEMP_W'($urandom_range(0, 100)));
            if ($urandom_range(0, 5) == 0)
                write_register(IDX_W'($urandom_range(REG_UNMAPPED_LO, REG_UNMAPPED_HI)),
                               CFG_W'($urandom));

            burst_left = $urandom_range(1, 30);
            pass_left  = $urandom_range(1, 8);
            for (n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                case ($urandom_range(0, 9))
                    7: t = TEMP_W'($urandom);
                    8: t = ($urandom_range(0, 1) != 0) ? '0 : '1;
                    9: t = TEMP_W'($urandom_range(0, 255));
                    default: t = TEMP_W'($urandom_range(0, 100));
                endcase
                pass_left--;
                send_temperature(t, pass_left == 0, 1'b0, '0, '0);
                if (pass_left == 0)
                    pass_left = $urandom_range(1, 8);
                burst_left--;
                if (burst_left == 0)
                begin
                    gap = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40)
                                                      : $urandom_range(1, 12);
                    start <= 1'b0;
                    repeat (gap) @(posedge clk);
                    burst_left = $urandom_range(1, 30);
                end
            end
        end

        start <= 1'b0;
        drain_results();
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
